FILE: design/dsha_pkg.sv
`default_nettype none
package dsha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } dsha_in_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } dsha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } dsha_state_t;

  // which compression is running
  typedef enum logic [1:0] {
    PH_MSG,
    PH_FINAL,
    PH_SEC1,
    PH_SEC2
  } dsha_phase_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage
`default_nettype wire

FILE: design/double_sha1_package_mac.sv
// Double SHA-1 package MAC.
// Input channel (in_valid/in_stall/in_data): one request per message byte,
// with has_byte marking a real byte and last closing the message.
// Output channel (out_valid/out_stall/out_data): one request per message,
// the first 16 bytes of SHA-1 over a block built from the message digest.
// A byte request that does not fill a block is stored in the buffer.
// A byte that fills a 64-byte block runs one compression on the shared
// round unit and then folds the result into the chain.
// A last request runs three or four compressions (padding, an optional extra
// padded block, then the two blocks of the outer hash) before out_valid
// rises. The block stalls input while compressing and while a result
// waits; out_data holds while out_stall is high.
// Reset (rst_n low, synchronous) loads the SHA-1 initial values, clears
// the byte count and length, and drops out_valid. The 16-word message
// buffer holds no reset value; it is always fully written before use.
`default_nettype none
module double_sha1_package_mac
  import dsha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dsha_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output dsha_out_t      out_data
);

  dsha_state_t state_r, state_nxt;
  dsha_phase_t phase_r, phase_nxt;

  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [31:0] w_r [BlockWords];
  logic [31:0] w_nxt [BlockWords];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic        extra_r, extra_nxt;
  dsha_out_t   out_r, out_nxt;

  logic [31:0] f, k, t, wnew;
  logic [159:0] dg;
  logic [7:0]   db [32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_MSG;
      pos_r   <= '0;
      len_r   <= '0;
      rnd_r   <= '0;
      extra_r <= 1'b0;
      h_r[0] <= IV0; h_r[1] <= IV1; h_r[2] <= IV2; h_r[3] <= IV3; h_r[4] <= IV4;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      rnd_r   <= rnd_nxt;
      extra_r <= extra_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    out_r <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = (state_r == ST_OUT);
  assign in_stall  = (state_r != ST_IDLE);

  // shared round unit
  always_comb begin
    priority if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);  k = 32'h5A827999;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;             k = 32'h6ED9EBA1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r;             k = 32'hCA62C1D6;
    end
    t    = rotl(a_r, 5) + f + e_r + k + w_r[0];
    wnew = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
  end

  // digest bytes for second block, from the chain after the fold
  always_comb begin
    dg = {h_r[0] + a_r, h_r[1] + b_r, h_r[2] + c_r, h_r[3] + d_r, h_r[4] + e_r};
    for (int i = 0; i < 8; i++) begin
      db[i]     = dg[159 - 8*(4+i) -: 8];
      db[8 + i] = dg[159 - 8*(4+i) -: 8];
    end
    for (int i = 0; i < 4; i++) db[16 + i] = dg[159 - 8*(12+i) -: 8];
    db[20] = dg[159 - 8*16 -: 8];
    db[21] = dg[159 - 8*1 -: 8];
    db[22] = dg[159 - 8*2 -: 8];
    db[23] = dg[159 - 8*3 -: 8];
    for (int i = 0; i < 8; i++) db[24 + i] = db[16 + i];
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    h_nxt     = h_r;
    w_nxt     = w_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    rnd_nxt   = rnd_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    extra_nxt = extra_r;
    out_nxt   = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.has_byte) begin
            w_nxt[pos_r[5:2]][{~pos_r[1:0], 3'd0} +: 8] = in_data.data_byte;
            len_nxt = len_r + 64'd8;
            pos_nxt = pos_r + 6'd1;
          end
          priority if (in_data.has_byte && pos_r == 6'd63) begin
            a_nxt = h_r[0]; b_nxt = h_r[1]; c_nxt = h_r[2]; d_nxt = h_r[3]; e_nxt = h_r[4];
            rnd_nxt   = '0;
            phase_nxt = PH_MSG;
            extra_nxt = in_data.last;
            state_nxt = ST_ROUND;
          end else if (in_data.last) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        // pos_r is the first free byte; all later lanes are zeroed
        for (int i = 0; i < 64; i++) begin
          if (6'(i) == pos_r) w_nxt[i/4][24 - 8*(i%4) +: 8] = 8'h80;
          else if (6'(i) > pos_r) w_nxt[i/4][24 - 8*(i%4) +: 8] = 8'h00;
        end
        if (pos_r < 6'd56) begin
          w_nxt[14] = len_r[63:32];
          w_nxt[15] = len_r[31:0];
          phase_nxt = PH_FINAL;
          pos_nxt   = '0;
        end else begin
          phase_nxt = PH_MSG;
        end
        extra_nxt = (pos_r >= 6'd56);
        a_nxt = h_r[0]; b_nxt = h_r[1]; c_nxt = h_r[2]; d_nxt = h_r[3]; e_nxt = h_r[4];
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end

      ST_ROUND: begin
        e_nxt = d_r; d_nxt = c_r; c_nxt = rotl(b_r, 30); b_nxt = a_r; a_nxt = t;
        for (int i = 0; i < BlockWords - 1; i++) w_nxt[i] = w_r[i + 1];
        w_nxt[BlockWords - 1] = wnew;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(Rounds - 1)) state_nxt = ST_FOLD;
      end

      ST_FOLD: begin
        h_nxt[0] = h_r[0] + a_r; h_nxt[1] = h_r[1] + b_r; h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r; h_nxt[4] = h_r[4] + e_r;
        rnd_nxt  = '0;
        unique case (phase_r)
          PH_MSG: begin
            if (extra_r) begin
              // block just finished; pad into the next one
              for (int i = 0; i < BlockWords; i++) w_nxt[i] = '0;
              state_nxt = ST_PAD;
              extra_nxt = 1'b0;
              if (pos_r != 6'd0) begin
                // padding byte already placed; only the length block remains
                w_nxt[14] = len_r[63:32];
                w_nxt[15] = len_r[31:0];
                phase_nxt = PH_FINAL;
                a_nxt = h_nxt[0]; b_nxt = h_nxt[1]; c_nxt = h_nxt[2];
                d_nxt = h_nxt[3]; e_nxt = h_nxt[4];
                state_nxt = ST_ROUND;
              end
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          PH_FINAL: begin
            for (int i = 0; i < 8; i++)
              w_nxt[i] = {db[4*i], db[4*i+1], db[4*i+2], db[4*i+3]};
            for (int i = 8; i < BlockWords; i++) w_nxt[i] = '0;
            h_nxt[0] = IV0; h_nxt[1] = IV1; h_nxt[2] = IV2; h_nxt[3] = IV3; h_nxt[4] = IV4;
            a_nxt = IV0; b_nxt = IV1; c_nxt = IV2; d_nxt = IV3; e_nxt = IV4;
            phase_nxt = PH_SEC1;
            state_nxt = ST_ROUND;
          end
          PH_SEC1: begin
            for (int i = 0; i < BlockWords; i++) w_nxt[i] = '0;
            w_nxt[0]  = 32'h80000000;
            w_nxt[15] = 32'd512;
            a_nxt = h_nxt[0]; b_nxt = h_nxt[1]; c_nxt = h_nxt[2];
            d_nxt = h_nxt[3]; e_nxt = h_nxt[4];
            phase_nxt = PH_SEC2;
            state_nxt = ST_ROUND;
          end
          PH_SEC2: begin
            out_nxt.digest_high = {h_nxt[0], h_nxt[1]};
            out_nxt.digest_low  = {h_nxt[2], h_nxt[3]};
            h_nxt[0] = IV0; h_nxt[1] = IV1; h_nxt[2] = IV2; h_nxt[3] = IV3; h_nxt[4] = IV4;
            pos_nxt   = '0;
            len_nxt   = '0;
            phase_nxt = PH_MSG;
            state_nxt = ST_OUT;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> rnd_r < 7'(Rounds))
    else $error("round counter overran");
  a_fold_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FOLD |-> $past(state_r) == ST_ROUND)
    else $error("fold without rounds");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_out_from_fold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_FOLD && $past(phase_r) == PH_SEC2)
    else $error("result without outer hash");

endmodule
`default_nettype wire
